>>> rtl/dht_pkg.sv
// Package for the double-hashing table engine: widths, codes and beat types.
// Used by double_hash_table_engine and its testbench; depends on nothing.
package dht_pkg;

  localparam int MAX_LG   = 10;
  localparam int MIN_LG   = 4;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int HASH_W   = 32;
  localparam int SLOT_W   = MAX_LG;
  localparam int CNT_W    = MAX_LG + 1;
  localparam int LG_W     = 4;
  localparam int ADDR_W   = SLOT_W + 1;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  localparam logic [LG_W-1:0]   INIT_LG_RESET = LG_W'(4);
  localparam logic [HASH_W-1:0] GOLDEN = 32'h9E37_79B9;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_ADD    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic [1:0] ST_MISS     = 2'd0;
  localparam logic [1:0] ST_FOUND    = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] TAG_FREE = 2'd0;
  localparam logic [1:0] TAG_LIVE = 2'd1;
  localparam logic [1:0] TAG_TOMB = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      key_code;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [VAL_W-1:0]  found_value;
    logic [SLOT_W-1:0] slot_index;
    logic [CNT_W-1:0]  live_count;
    logic [LG_W-1:0]   current_size_log2;
  } result_t;

  typedef struct packed {
    logic [1:0]        tag;
    logic [HASH_W-1:0] hash;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } entry_t;

endpackage

>>> rtl/dht_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/double_hash_table_engine.sv
// Top level of the double-hashing table engine: sequencer, probe unit, resize.
// Depends on dht_pkg and dht_ram (one RAM holds both banks of entries).
//
//   channel  | signals                | beat taken when
//   ---------+------------------------+--------------------------
//   request  | start, busy, cmd       | start & !busy
//   result   | done, result           | done (one cycle, no stall)
//   config   | cfg_we, cfg_data       | cfg_we
//
// A lookup/remove/add probes the table one step at a time through the single
// RAM read port. A resize reads every old slot, probes each moved entry into
// the other bank, sweeps the old bank free and, after a growth, probes to
// place the new entry. A clear sweeps every slot of the current size. After
// reset the block is busy while it sweeps both banks free. Results cannot be
// stalled.
module double_hash_table_engine
  import dht_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cmd_t            cmd,
  output logic            done,
  output result_t         result,
  input  logic            cfg_we,
  input  logic [LG_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_RST_CLR, S_IDLE, S_HASH, S_PSET, S_PRD, S_PCHK, S_PDONE,
    S_RH_RD, S_RH_CHK, S_RH_CLR, S_CLR, S_FIN
  } state_t;

  typedef enum logic [1:0] {MODE_REQ, MODE_RH, MODE_INS} mode_t;

  state_t state;
  mode_t  p_mode;

  cmd_t              cmd_q;
  logic [HASH_W-1:0] h_q;
  logic              active_bank;
  logic [LG_W-1:0]   size_lg;
  logic [CNT_W-1:0]  entry_count;
  logic [CNT_W-1:0]  tomb_count;
  logic [LG_W-1:0]   init_lg;

  logic              p_bank;
  logic [LG_W-1:0]   p_lg;
  logic [HASH_W-1:0] p_h;
  logic [KEY_W-1:0]  p_key;
  logic [SLOT_W-1:0] p_i;
  logic [SLOT_W-1:0] p_step;
  logic [CNT_W-1:0]  p_n;
  logic              p_hit;
  logic              p_free;
  logic [SLOT_W-1:0] p_at;
  logic [VAL_W-1:0]  p_val;

  logic [SLOT_W-1:0] rh_i;
  logic [LG_W-1:0]   rh_lg;
  logic              rh_grow;
  logic [VAL_W-1:0]  rh_val;

  logic [1:0]        res_status;
  logic [VAL_W-1:0]  res_fval;
  logic [SLOT_W-1:0] res_slot;

  logic [ADDR_W-1:0] sw_addr;
  logic [ADDR_W-1:0] sw_last;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            rd;

  // Shared arithmetic
  logic [HASH_W-1:0] code_sat;
  logic [HASH_W-1:0] prod;
  logic [5:0]        p_shift;
  logic [HASH_W-1:0] h_shl;
  logic [CNT_W-1:0]  p_size;
  logic [SLOT_W-1:0] p_mask;
  logic [CNT_W-1:0]  size;
  logic [SLOT_W-1:0] mask;
  logic [CNT_W-1:0]  add_cnt;
  logic [CNT_W-1:0]  grow_thr;
  logic              add_grow;
  logic              add_full;
  logic              rm_shrink;
  logic [LG_W-1:0]   init_clamped;

  localparam logic [LG_W-1:0] MAX_LG_C = LG_W'(MAX_LG);
  localparam logic [LG_W-1:0] MIN_LG_C = LG_W'(MIN_LG);

  always_comb begin
    code_sat = (cmd_q.key_code < 32'd2) ? 32'd2 : cmd_q.key_code;
    prod     = code_sat * GOLDEN;
    p_shift  = 6'd32 - 6'(p_lg);
    h_shl    = p_h << p_lg;
    p_size   = CNT_W'(1) << p_lg;
    p_mask   = SLOT_W'(p_size - CNT_W'(1));
    size     = CNT_W'(1) << size_lg;
    mask     = SLOT_W'(size - CNT_W'(1));
    add_cnt  = entry_count + tomb_count + CNT_W'(1);
    grow_thr = size - (size >> 2);
    add_grow = (add_cnt >= grow_thr) && (size_lg < MAX_LG_C);
    add_full = (add_cnt >= grow_thr) && (size_lg >= MAX_LG_C) && (add_cnt == size);
    rm_shrink = (size_lg > MIN_LG_C) && ((entry_count - CNT_W'(1)) <= (size >> 2));
    if (init_lg > MAX_LG_C) begin
      init_clamped = MAX_LG_C;
    end else if (init_lg < MIN_LG_C) begin
      init_clamped = MIN_LG_C;
    end else begin
      init_clamped = init_lg;
    end
  end

  // RAM port control
  always_comb begin
    ram_raddr = {p_bank, p_i};
    if (state == S_RH_RD) begin
      ram_raddr = {active_bank, rh_i};
    end
    ram_we    = 1'b0;
    ram_waddr = sw_addr;
    ram_wdata = '{tag: TAG_FREE, hash: '0, key: p_key, value: p_val};
    unique case (state)
      S_RST_CLR, S_CLR, S_RH_CLR: begin
        ram_we = 1'b1;
      end
      S_PDONE: begin
        unique case (p_mode)
          MODE_REQ: begin
            ram_waddr = {active_bank, p_at};
            if (cmd_q.func == FUNC_ADD && !p_hit && p_free && !add_grow && !add_full) begin
              ram_we    = 1'b1;
              ram_wdata = '{tag: TAG_LIVE, hash: h_q, key: cmd_q.key, value: cmd_q.value};
            end else if (cmd_q.func == FUNC_REMOVE && p_hit) begin
              ram_we    = 1'b1;
              ram_wdata = '{tag: TAG_TOMB, hash: '0, key: p_key, value: p_val};
            end
          end
          MODE_RH: begin
            ram_we    = p_free;
            ram_waddr = {p_bank, p_at};
            ram_wdata = '{tag: TAG_LIVE, hash: p_h, key: p_key, value: rh_val};
          end
          default: begin
            ram_we    = p_free;
            ram_waddr = {p_bank, p_at};
            ram_wdata = '{tag: TAG_LIVE, hash: h_q, key: cmd_q.key, value: cmd_q.value};
          end
        endcase
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  dht_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_RST_CLR;
      sw_addr     <= '0;
      sw_last     <= '1;
      active_bank <= 1'b0;
      size_lg     <= INIT_LG_RESET;
      entry_count <= '0;
      tomb_count  <= '0;
      init_lg     <= INIT_LG_RESET;
      done        <= 1'b0;
      p_mode      <= MODE_REQ;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        init_lg <= cfg_data;
      end
      unique case (state)
        S_RST_CLR: begin
          sw_addr <= sw_addr + ADDR_W'(1);
          if (sw_addr == sw_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            state <= S_HASH;
          end
        end
        S_HASH: begin
          h_q        <= prod;
          res_status <= ST_MISS;
          res_fval   <= '0;
          res_slot   <= '0;
          if (cmd_q.func == FUNC_CLEAR) begin
            sw_addr <= {active_bank, SLOT_W'(0)};
            sw_last <= {active_bank, mask};
            state   <= S_CLR;
          end else begin
            p_bank <= active_bank;
            p_lg   <= size_lg;
            p_h    <= prod;
            p_key  <= cmd_q.key;
            p_mode <= MODE_REQ;
            state  <= S_PSET;
          end
        end
        S_PSET: begin
          p_i    <= SLOT_W'(p_h >> p_shift);
          p_step <= SLOT_W'(h_shl >> p_shift) | SLOT_W'(1);
          p_n    <= '0;
          state  <= S_PRD;
        end
        S_PRD: begin
          state <= S_PCHK;
        end
        S_PCHK: begin
          if (rd.tag == TAG_FREE) begin
            p_hit  <= 1'b0;
            p_free <= 1'b1;
            p_at   <= p_i;
            state  <= S_PDONE;
          end else if (rd.tag == TAG_LIVE && rd.hash == p_h && rd.key == p_key) begin
            p_hit  <= 1'b1;
            p_free <= 1'b0;
            p_at   <= p_i;
            p_val  <= rd.value;
            state  <= S_PDONE;
          end else if (p_n == p_size - CNT_W'(1)) begin
            p_hit  <= 1'b0;
            p_free <= 1'b0;
            p_at   <= '0;
            state  <= S_PDONE;
          end else begin
            p_i   <= (p_i - p_step) & p_mask;
            p_n   <= p_n + CNT_W'(1);
            state <= S_PRD;
          end
        end
        S_PDONE: begin
          unique case (p_mode)
            MODE_REQ: begin
              state <= S_FIN;
              case (cmd_q.func)
                FUNC_LOOKUP: begin
                  if (p_hit) begin
                    res_status <= ST_FOUND;
                    res_fval   <= p_val;
                    res_slot   <= p_at;
                  end
                end
                FUNC_REMOVE: begin
                  if (p_hit) begin
                    res_status  <= ST_FOUND;
                    res_fval    <= p_val;
                    entry_count <= entry_count - CNT_W'(1);
                    tomb_count  <= tomb_count + CNT_W'(1);
                    if (rm_shrink) begin
                      rh_lg   <= size_lg - LG_W'(1);
                      rh_grow <= 1'b0;
                      rh_i    <= '0;
                      state   <= S_RH_RD;
                    end
                  end
                end
                default: begin
                  if (p_hit) begin
                    res_status <= ST_FOUND;
                    res_fval   <= p_val;
                    res_slot   <= p_at;
                  end else if (!p_free || add_full) begin
                    res_status <= ST_FULL;
                  end else begin
                    res_status  <= ST_INSERTED;
                    res_fval    <= cmd_q.value;
                    res_slot    <= p_at;
                    entry_count <= entry_count + CNT_W'(1);
                    if (add_grow) begin
                      rh_lg   <= size_lg + LG_W'(1);
                      rh_grow <= 1'b1;
                      rh_i    <= '0;
                      state   <= S_RH_RD;
                    end
                  end
                end
              endcase
            end
            MODE_RH: begin
              if (rh_i == mask) begin
                sw_addr <= {active_bank, SLOT_W'(0)};
                sw_last <= {active_bank, mask};
                state   <= S_RH_CLR;
              end else begin
                rh_i  <= rh_i + SLOT_W'(1);
                state <= S_RH_RD;
              end
            end
            default: begin
              res_slot <= p_free ? p_at : SLOT_W'(0);
              state    <= S_FIN;
            end
          endcase
        end
        S_RH_RD: begin
          state <= S_RH_CHK;
        end
        S_RH_CHK: begin
          if (rd.tag == TAG_LIVE) begin
            p_bank <= ~active_bank;
            p_lg   <= rh_lg;
            p_h    <= rd.hash;
            p_key  <= rd.key;
            rh_val <= rd.value;
            p_mode <= MODE_RH;
            state  <= S_PSET;
          end else if (rh_i == mask) begin
            sw_addr <= {active_bank, SLOT_W'(0)};
            sw_last <= {active_bank, mask};
            state   <= S_RH_CLR;
          end else begin
            rh_i  <= rh_i + SLOT_W'(1);
            state <= S_RH_RD;
          end
        end
        S_RH_CLR: begin
          sw_addr <= sw_addr + ADDR_W'(1);
          if (sw_addr == sw_last) begin
            active_bank <= ~active_bank;
            size_lg     <= rh_lg;
            tomb_count  <= '0;
            if (rh_grow) begin
              // new entry goes in last, into the fresh bank
              p_bank <= ~active_bank;
              p_lg   <= rh_lg;
              p_h    <= h_q;
              p_key  <= cmd_q.key;
              p_mode <= MODE_INS;
              state  <= S_PSET;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_CLR: begin
          sw_addr <= sw_addr + ADDR_W'(1);
          if (sw_addr == sw_last) begin
            size_lg     <= init_clamped;
            entry_count <= '0;
            tomb_count  <= '0;
            state       <= S_FIN;
          end
        end
        S_FIN: begin
          result.status            <= res_status;
          result.found_value       <= res_fval;
          result.slot_index        <= res_slot;
          result.live_count        <= entry_count;
          result.current_size_log2 <= size_lg;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/tb_double_hash_table_engine.sv
// Self-checking testbench for double_hash_table_engine: directed table, random phases, then a growth run.
// Needs dht_pkg and the engine RTL only; a built-in predictor tracks both banks of the table.
`timescale 1ns / 100ps

module tb_double_hash_table_engine
  import dht_pkg::*;
();

  localparam int BANK = 1 << MAX_LG;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk, rst, start, busy, done, cfg_we;
  logic [LG_W-1:0] cfg_data;
  cmd_t cmd;
  result_t result;

  double_hash_table_engine DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow table
  logic [1:0]  tag_m [2*BANK];
  logic [31:0] hash_m [2*BANK];
  logic [31:0] key_m [2*BANK];
  logic [31:0] val_m [2*BANK];
  int bank_m, lg_m, live_m, tomb_m, init_lg_m;

  result_t pending_results[$];
  bit failed = 1'b0;
  int beats_out = 0;
  int beats_in, full_seen, resizes, max_lg_seen;
  longint cycles = 0;

  function automatic int clamp_lg(int v);
    if (v > MAX_LG) return MAX_LG;
    if (v < MIN_LG) return MIN_LG;
    return v;
  endfunction

  // 1 hit, 0 free slot, -1 exhausted
  function automatic int probe_slot(int bank, int lg, logic [31:0] h, logic [31:0] k,
                                    output int at);
    int size, mask, i, n, a;
    logic [31:0] hs, step;
    size = 1 << lg;
    mask = size - 1;
    i = int'(h >> (32 - lg));
    hs = h << lg;
    step = (hs >> (32 - lg)) | 32'd1;
    for (n = 0; n < size; n++) begin
      a = bank * BANK + (i & mask);
      if (tag_m[a] == TAG_FREE) begin
        at = i & mask;
        return 0;
      end
      if (tag_m[a] == TAG_LIVE && hash_m[a] == h && key_m[a] == k) begin
        at = i & mask;
        return 1;
      end
      i = (i - int'(step)) & mask;
    end
    at = 0;
    return -1;
  endfunction

  function automatic void move_to_other_bank(int new_lg, int skip);
    int ob, nb, i, a, d, at;
    ob = bank_m;
    nb = ob ^ 1;
    for (i = 0; i < BANK; i++) tag_m[nb*BANK + i] = TAG_FREE;
    for (i = 0; i < (1 << lg_m); i++) begin
      a = ob * BANK + i;
      if (i != skip && tag_m[a] == TAG_LIVE &&
          probe_slot(nb, new_lg, hash_m[a], key_m[a], at) == 0) begin
        d = nb * BANK + at;
        tag_m[d] = TAG_LIVE;
        hash_m[d] = hash_m[a];
        key_m[d] = key_m[a];
        val_m[d] = val_m[a];
      end
    end
    for (i = 0; i < BANK; i++) tag_m[ob*BANK + i] = TAG_FREE;
    bank_m = nb;
    lg_m = new_lg;
    tomb_m = 0;
    resizes++;
  endfunction

  function automatic result_t predict_table(cmd_t c);
    result_t r;
    logic [31:0] code, h;
    int lg, size, hit, at, at2, a, d, i;
    r = '0;
    lg = lg_m;
    size = 1 << lg;
    code = (c.key_code < 2) ? 32'd2 : c.key_code;
    h = code * GOLDEN;
    if (c.func == FUNC_CLEAR) begin
      for (i = 0; i < 2*BANK; i++) begin
        tag_m[i] = TAG_FREE;
        hash_m[i] = '0;
      end
      lg_m = clamp_lg(init_lg_m);
      live_m = 0;
      tomb_m = 0;
    end else begin
      hit = probe_slot(bank_m, lg, h, c.key, at);
      a = bank_m * BANK + at;
      if (c.func == FUNC_LOOKUP) begin
        if (hit == 1) begin
          r.status = ST_FOUND;
          r.slot_index = SLOT_W'(at);
          r.found_value = val_m[a];
        end
      end else if (c.func == FUNC_REMOVE) begin
        if (hit == 1) begin
          r.status = ST_FOUND;
          r.found_value = val_m[a];
          tag_m[a] = TAG_TOMB;
          hash_m[a] = '0;
          tomb_m++;
          live_m--;
          if (lg > MIN_LG && live_m <= (size >> 2)) move_to_other_bank(lg - 1, size);
        end
      end else if (hit == 1) begin
        r.status = ST_FOUND;
        r.slot_index = SLOT_W'(at);
        r.found_value = val_m[a];
      end else if (hit < 0) begin
        r.status = ST_FULL;
      end else begin
        tag_m[a] = TAG_LIVE;
        hash_m[a] = h;
        key_m[a] = c.key;
        val_m[a] = c.value;
        live_m++;
        r.status = ST_INSERTED;
        r.slot_index = SLOT_W'(at);
        r.found_value = c.value;
        if (live_m + tomb_m >= size - (size >> 2)) begin
          if (lg < MAX_LG) begin
            at2 = 0;
            move_to_other_bank(lg + 1, at);
            if (probe_slot(bank_m, lg + 1, h, c.key, at2) == 0) begin
              d = bank_m * BANK + at2;
              tag_m[d] = TAG_LIVE;
              hash_m[d] = h;
              key_m[d] = c.key;
              val_m[d] = c.value;
            end
            r.slot_index = SLOT_W'(at2);
          end else if (live_m + tomb_m == size) begin
            tag_m[a] = TAG_FREE;
            hash_m[a] = '0;
            live_m--;
            r = '0;
            r.status = ST_FULL;
          end
        end
      end
    end
    r.live_count = CNT_W'(live_m);
    r.current_size_log2 = LG_W'(lg_m);
    if (r.status == ST_FULL) full_seen++;
    if (lg_m > max_lg_seen) max_lg_seen = lg_m;
    return r;
  endfunction

  // called just after a rising edge; returns just after the edge that took the beat
  task automatic issue_cmd(cmd_t c, bit typed = 1'b0, result_t typed_exp = '0);
    result_t r;
    start <= 1'b1;
    cmd <= c;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    r = predict_table(c);
    pending_results.push_back(typed ? typed_exp : r);
    beats_in++;
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_init_lg(logic [LG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    init_lg_m = int'(v);
    @(posedge clk);
  endtask

  task automatic sender_gap(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  always @(negedge clk) begin
    result_t want;
    if (!rst && done) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          failed = 1'b1;
        end
        if (result.found_value !== want.found_value) begin
          $error("found_value: expected %h, got %h", want.found_value, result.found_value);
          failed = 1'b1;
        end
        if (result.slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, result.slot_index);
          failed = 1'b1;
        end
        if (result.live_count !== want.live_count) begin
          $error("live_count: expected %0d, got %0d", want.live_count, result.live_count);
          failed = 1'b1;
        end
        if (result.current_size_log2 !== want.current_size_log2) begin
          $error("current_size_log2: expected %0d, got %0d",
                 want.current_size_log2, result.current_size_log2);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("double_hash_table_engine test failed");
      $finish;
    end
  end

  cmd_t dir_cmd[$];
  bit dir_typed[$];
  result_t dir_exp[$];

  function automatic void add_row(logic [1:0] f, logic [31:0] kc, logic [31:0] k,
                                  logic [31:0] v, bit typed = 1'b0, result_t e = '0);
    cmd_t c;
    c.func = f;
    c.key_code = kc;
    c.key = k;
    c.value = v;
    dir_cmd.push_back(c);
    dir_typed.push_back(typed);
    dir_exp.push_back(e);
  endfunction

  logic [31:0] pool_code[$];
  logic [31:0] pool_key[$];

  task automatic run_random(int init_lg, int idle_pct, int pool_n, int n_items);
    cmd_t c;
    int i, roll, p;
    wait_results_drained();
    write_init_lg(LG_W'(init_lg));
    pool_code.delete();
    pool_key.delete();
    for (i = 0; i < pool_n; i++) begin
      roll = $urandom_range(99);
      pool_key.push_back($urandom);
      if (roll < 8) pool_code.push_back($urandom_range(0, 1));
      else if (roll < 20 && i > 0) pool_code.push_back(pool_code[i-1]);
      else pool_code.push_back($urandom);
    end
    c = '0;
    c.func = FUNC_CLEAR;
    issue_cmd(c);
    for (i = 0; i < n_items; i++) begin
      roll = $urandom_range(999);
      p = $urandom_range(pool_n - 1);
      c.value = $urandom;
      if ($urandom_range(9) < 8) begin
        c.key_code = pool_code[p];
        c.key = pool_key[p];
      end else begin
        c.key_code = $urandom;
        c.key = $urandom;
      end
      if (roll < 480) c.func = FUNC_ADD;
      else if (roll < 720) c.func = FUNC_LOOKUP;
      else if (roll < 995) c.func = FUNC_REMOVE;
      else c.func = FUNC_CLEAR;
      issue_cmd(c);
      sender_gap(idle_pct);
    end
  endtask

  initial begin
    cmd_t c;
    result_t e;
    int i;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    cfg_we = 1'b0;
    cfg_data = INIT_LG_RESET;
    beats_in = 0;
    full_seen = 0;
    resizes = 0;
    max_lg_seen = 0;
    for (i = 0; i < 2*BANK; i++) begin
      tag_m[i] = TAG_FREE;
      hash_m[i] = '0;
    end
    bank_m = 0;
    init_lg_m = int'(INIT_LG_RESET);
    lg_m = clamp_lg(init_lg_m);
    live_m = 0;
    tomb_m = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    write_init_lg(4'd4);

    // directed: empty table, hash code floor, duplicate add, miss, growth, shrink, clear
    e = '0;
    e.status = ST_MISS;
    e.current_size_log2 = LG_W'(4);
    add_row(FUNC_LOOKUP, 32'd5, 32'd5, 32'd0, 1'b1, e);
    add_row(FUNC_ADD, 32'd0, 32'd0, 32'd0);
    add_row(FUNC_ADD, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_row(FUNC_ADD, 32'd1, 32'hFFFF_FFFF, 32'h1234_5678);
    add_row(FUNC_LOOKUP, 32'd0, 32'hFFFF_FFFF, 32'd0);
    add_row(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'd0, 32'd0);
    add_row(FUNC_REMOVE, 32'd0, 32'd0, 32'd0);
    add_row(FUNC_REMOVE, 32'd0, 32'd0, 32'd0);
    for (i = 0; i < 10; i++) add_row(FUNC_ADD, i * 77 + 3, i + 10, 32'hA500_0000 + i);
    for (i = 0; i < 5; i++) add_row(FUNC_REMOVE, i * 77 + 3, i + 10, 32'd0);
    add_row(FUNC_LOOKUP, 32'd80, 32'd11, 32'd0);
    add_row(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, e);
    for (i = 0; i < dir_cmd.size(); i++) issue_cmd(dir_cmd[i], dir_typed[i], dir_exp[i]);

    run_random(4, 0, 24, 90);
    run_random(0, 65, 150, 90);
    run_random(15, 7, 500, 90);
    run_random(5, 65, 40, 90);

    // grow from the smallest table up to the largest, then touch it
    wait_results_drained();
    write_init_lg(4'd4);
    c = '0;
    c.func = FUNC_CLEAR;
    issue_cmd(c);
    for (i = 0; i < 540; i++) begin
      c.func = FUNC_ADD;
      c.key_code = $urandom;
      c.key = i;
      c.value = $urandom;
      issue_cmd(c);
    end
    for (i = 0; i < 20; i++) begin
      c.func = (i % 2) ? FUNC_REMOVE : FUNC_LOOKUP;
      c.key_code = $urandom;
      c.key = $urandom_range(0, 539);
      issue_cmd(c);
    end
    c.func = FUNC_CLEAR;
    issue_cmd(c);

    wait_results_drained();
    repeat (50) @(posedge clk);
    $display("ran %0d request beats, %0d results; %0d resizes, %0d full replies, max size 2^%0d",
             beats_in, beats_out, resizes, full_seen, max_lg_seen);
    if (!failed && pending_results.size() == 0) begin
      $display("double_hash_table_engine test passed");
    end else begin
      $display("double_hash_table_engine test failed");
    end
    $finish;
  end

endmodule
